>>> src/can_id_filtered_rx_queues_defines.svh
// ----------------------------------------------------------------------------
// can_id_filtered_rx_queues_defines
// Assertion macros for the receive queue engine (canq_back). Each macro expects
// clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef CAN_ID_FILTERED_RX_QUEUES_DEFINES_SVH
`define CAN_ID_FILTERED_RX_QUEUES_DEFINES_SVH

// Consequence holds in the same cycle as the antecedent.
`define CANQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("canq assertion failed");

// Consequence holds in the cycle after the antecedent.
`define CANQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("canq assertion failed");

`endif

>>> src/canq_pkg.sv
// ----------------------------------------------------------------------------
// canq_pkg
// Types and constants for the filtered CAN receive queues.
// ----------------------------------------------------------------------------
package canq_pkg;

  localparam int ID_W     = 11;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 3;
  localparam int CNT_W    = 32;
  localparam int HDR_W    = ID_W + LEN_W;
  localparam int QIDX_W   = 4;
  localparam int NUM_REGS = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd4;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_COUNT,
    CMD_UNKNOWN
  } cmd_op_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ID_W-1:0]   std_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_data;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [LEN_W-1:0]    out_len;
    logic [DATA_W-1:0]   out_data;
    logic [FILL_W-1:0]   fill_count;
    logic [CNT_W-1:0]    received_count;
    logic [CNT_W-1:0]    dropped_count;
  } result_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [QIDX_W-1:0] qidx;
    logic [ID_W-1:0]   std_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_data;
  } cmd_t;

endpackage

>>> src/canq_ram.sv
// ----------------------------------------------------------------------------
// canq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module canq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/canq_front.sv
// ----------------------------------------------------------------------------
// canq_front
// Acceptance filter and two-entry command queue feeding the queue engine.
// ----------------------------------------------------------------------------
module canq_front #(
  parameter int NUM_QUEUES = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  canq_pkg::item_t       item,
  input  logic [10:0]           queue_id [NUM_QUEUES],
  output logic                  cmd_valid,
  input  logic                  cmd_take,
  output canq_pkg::cmd_t        cmd
);
  import canq_pkg::*;

  cmd_t              slot [2];
  cmd_t              cmd_in;
  logic              wr_sel;
  logic              rd_sel;
  logic [1:0]        fill;
  logic              push;
  logic              hit;
  logic [QIDX_W-1:0] hit_q;

  // Last match wins, so the highest-numbered queue takes the ID.
  always_comb begin
    hit   = 1'b0;
    hit_q = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (queue_id[q] == item.std_id) begin
        hit   = 1'b1;
        hit_q = QIDX_W'(q);
      end
    end
  end

  always_comb begin
    cmd_in.qidx       = hit_q;
    cmd_in.std_id     = item.std_id;
    cmd_in.frame_len  = item.frame_len;
    cmd_in.frame_data = item.frame_data;
    if (!hit) begin
      cmd_in.op = CMD_UNKNOWN;
    end else begin
      unique case (item.mode)
        MODE_PUSH: cmd_in.op = CMD_PUSH;
        MODE_POP:  cmd_in.op = CMD_POP;
        default:   cmd_in.op = CMD_COUNT;
      endcase
    end
  end

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (cmd_take) begin
        rd_sel <= ~rd_sel;
      end
      if (push && !cmd_take) begin
        fill <= fill + 2'd1;
      end else if (!push && cmd_take) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> src/canq_back.sv
// ----------------------------------------------------------------------------
// canq_back
// Queue engine: ring pointers, counters and slot RAM; forms one result per
// command.
// ----------------------------------------------------------------------------
`include "can_id_filtered_rx_queues_defines.svh"

module canq_back #(
  parameter int NUM_QUEUES  = 3,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  canq_pkg::cmd_t    cmd,
  output logic              cmd_take,
  output logic              done,
  output canq_pkg::result_t result
);
  import canq_pkg::*;

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW     = $clog2(QUEUE_DEPTH);
  localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = HDR_W + DATA_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [PW-1:0]     wp   [NUM_QUEUES];
  logic [PW-1:0]     rp   [NUM_QUEUES];
  logic [CNT_W-1:0]  acc  [NUM_QUEUES];
  logic [CNT_W-1:0]  lost [NUM_QUEUES];
  logic              done_next;
  result_t           result_next;

  logic [QW-1:0]     q;
  logic [PW-1:0]     wp_q;
  logic [PW-1:0]     rp_q;
  logic [PW-1:0]     wp_adv;
  logic [PW-1:0]     rp_adv;
  logic              full;
  logic              empty;
  logic [PW:0]       fill_w;
  logic [PW+3:0]     fill_ext;
  logic [AW-1:0]     base;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [SLOT_W-1:0] wdata;
  logic [SLOT_W-1:0] rdata;

  assign q      = cmd.qidx[QW-1:0];
  assign wp_q   = wp[q];
  assign rp_q   = rp[q];
  assign wp_adv = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_adv = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full   = (wp_adv == rp_q);
  assign empty  = (wp_q == rp_q);

  // Wrap the difference back into range when the writer is behind.
  assign fill_w   = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
                  : ({1'b0, wp_q} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp_q});
  assign fill_ext = (PW+4)'(fill_w);

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign ram_we   = cmd_take && (cmd.op == CMD_PUSH) && !full;
  assign ram_re   = cmd_take && (cmd.op == CMD_POP) && !empty;

  assign base  = AW'(q) * AW'(QUEUE_DEPTH);
  assign waddr = base + AW'(wp_q);
  assign raddr = base + AW'(rp_q);
  assign wdata = {cmd.frame_len, cmd.std_id, cmd.frame_data};

  canq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    result_next = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          done_next = 1'b1;
          unique case (cmd.op)
            CMD_PUSH: begin
              result_next.status = full ? ST_FULL : ST_OK;
            end
            CMD_POP: begin
              if (empty) begin
                result_next.status = ST_EMPTY;
              end else begin
                // hold the result until the slot read returns
                done_next  = 1'b0;
                state_next = S_READ;
              end
            end
            CMD_COUNT: begin
              result_next.status         = ST_COUNT;
              result_next.fill_count     = fill_ext[FILL_W-1:0];
              result_next.received_count = acc[q];
              result_next.dropped_count  = lost[q];
            end
            CMD_UNKNOWN: begin
              result_next.status = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_READ: begin
        done_next           = 1'b1;
        state_next          = S_IDLE;
        result_next.status  = ST_OK;
        result_next.out_data = rdata[DATA_W-1:0];
        result_next.out_id  = rdata[DATA_W +: ID_W];
        result_next.out_len = rdata[DATA_W+ID_W +: LEN_W];
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wp[i]   <= '0;
        rp[i]   <= '0;
        acc[i]  <= '0;
        lost[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      if (ram_we) begin
        wp[q]  <= wp_adv;
        acc[q] <= acc[q] + 1'b1;
      end
      if (cmd_take && (cmd.op == CMD_PUSH) && full) begin
        lost[q] <= lost[q] + 1'b1;
      end
      if (ram_re) begin
        rp[q] <= rp_adv;
      end
    end
  end

  `CANQ_ASSERT_NEXT(a_pop_waits_read, ram_re, state == S_READ && !done)
  `CANQ_ASSERT_NEXT(a_read_gives_ok, state == S_READ,
                    done && result.status == ST_OK && state == S_IDLE)
  `CANQ_ASSERT_NOW(a_no_take_in_read, state == S_READ, !cmd_take)
  `CANQ_ASSERT_NEXT(a_unknown_status, cmd_take && cmd.op == CMD_UNKNOWN,
                    done && result.status == ST_UNKNOWN)

endmodule

>>> src/can_id_filtered_rx_queues.sv
// ----------------------------------------------------------------------------
// can_id_filtered_rx_queues - ID-filtered CAN receive queues
// Path: the front command queue holds the item, then done and result are registered
// on take; a frame pop adds the slot RAM read. Throughput: one item/cycle unless busy.
// Reset: pointers and counters clear, IDs load q+1; slot RAM is not cleared.
// ----------------------------------------------------------------------------
module can_id_filtered_rx_queues #(
  parameter int NUM_QUEUES  = 3,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [canq_pkg::PADDR_W-1:0]   paddr,
  input  logic [canq_pkg::PDATA_W-1:0]   pwdata,
  output logic [canq_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  canq_pkg::item_t                item,
  output logic                           done,
  output canq_pkg::result_t              result
);
  import canq_pkg::*;

  logic [ID_W-1:0] queue_id [NUM_QUEUES];
  logic [ID_W-1:0] rd_val   [NUM_REGS];
  logic [1:0]      reg_idx;
  logic            cfg_wr;
  logic            cmd_valid;
  logic            cmd_take;
  cmd_t            cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Queues beyond the register list keep their reset ID.
  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_qid
    if (g < NUM_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          queue_id[g] <= ID_W'(g + 1);
        end else if (cfg_wr && (reg_idx == 2'(g))) begin
          queue_id[g] <= pwdata[ID_W-1:0];
        end
      end
    end else begin : g_fixed
      assign queue_id[g] = ID_W'(g + 1);
    end
  end

  for (genvar g = 0; g < NUM_REGS; g++) begin : g_rd
    if (g < NUM_QUEUES) begin : g_live
      assign rd_val[g] = queue_id[g];
    end else begin : g_none
      assign rd_val[g] = '0;
    end
  end

  assign prdata = (32'(reg_idx) < 32'(NUM_REGS)) ? PDATA_W'(rd_val[reg_idx]) : '0;

  canq_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .queue_id  (queue_id),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  canq_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .done      (done),
    .result    (result)
  );

endmodule

>>> tb/can_id_filtered_rx_queues_tb.sv
// ----------------------------------------------------------------------------
// can_id_filtered_rx_queues_tb
// Self-checking bench for the ID-filtered CAN receive queues. Programs the
// three filter IDs over APB and reads them back. Drives push, pop and count
// commands with and without random gaps. Predicts every result from a local copy of the
// rings, pointers and counters, and compares each result field by field.
// ----------------------------------------------------------------------------
module can_id_filtered_rx_queues_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import canq_pkg::*;

  localparam int NUM_FILTERS    = 3;
  localparam int RING_SLOTS     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  // Filter register indexes; the last one lies past the register list
  localparam int REG_QUEUE0_ID = 0;
  localparam int REG_QUEUE1_ID = 1;
  localparam int REG_QUEUE2_ID = 2;
  localparam int REG_UNUSED    = 3;

  // Mode three is served as a count query
  localparam logic [1:0] MODE_ALIAS_COUNT = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 start;
  logic                 busy;
  item_t                item_in;
  logic                 done;
  result_t              result_out;

  // Local copy of filters, rings and counters
  logic [ID_W-1:0]   queue_id     [NUM_FILTERS];
  logic [2:0]        wr_ptr       [NUM_FILTERS];
  logic [2:0]        rd_ptr       [NUM_FILTERS];
  logic [ID_W-1:0]   slot_id      [NUM_FILTERS][RING_SLOTS];
  logic [LEN_W-1:0]  slot_len     [NUM_FILTERS][RING_SLOTS];
  logic [DATA_W-1:0] slot_payload [NUM_FILTERS][RING_SLOTS];
  logic [CNT_W-1:0]  frames_in    [NUM_FILTERS];
  logic [CNT_W-1:0]  frames_lost  [NUM_FILTERS];

  result_t expected_results[$];
  result_t got;
  result_t want;
  int      mismatch_count;
  int      result_index;
  int      idle_cycles;

  can_id_filtered_rx_queues dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .item    (item_in),
    .done    (done),
    .result  (result_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %0h expected %0h",
               result_index, what, got_v, want_v);
    end
    mismatch_count++;
  endtask

  // Route the command through the filters and update the rings
  function automatic result_t apply_queue_op(input item_t it);
    result_t    r;
    int         hit;
    logic [2:0] wp;
    logic [2:0] rp;
    logic [2:0] nxt;
    r   = '0;
    hit = -1;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      if (queue_id[i] == it.std_id) hit = i;
    end
    if (hit < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    wp = wr_ptr[hit];
    rp = rd_ptr[hit];
    case (it.mode)
      MODE_PUSH: begin
        nxt = wp + 3'd1;  // eight slots: the 3-bit add wraps the ring
        if (nxt == rp) begin
          frames_lost[hit] = frames_lost[hit] + 1;
          r.status = ST_FULL;
        end else begin
          slot_id[hit][wp]      = it.std_id;
          slot_len[hit][wp]     = it.frame_len;
          slot_payload[hit][wp] = it.frame_data;
          wr_ptr[hit]           = nxt;
          frames_in[hit]        = frames_in[hit] + 1;
          r.status = ST_OK;
        end
      end
      MODE_POP: begin
        if (wp == rp) begin
          r.status = ST_EMPTY;
        end else begin
          r.status   = ST_OK;
          r.out_id   = slot_id[hit][rp];
          r.out_len  = slot_len[hit][rp];
          r.out_data = slot_payload[hit][rp];
          rd_ptr[hit] = rp + 3'd1;
        end
      end
      default: begin
        r.status         = ST_COUNT;
        r.fill_count     = wp - rp;
        r.received_count = frames_in[hit];
        r.dropped_count  = frames_lost[hit];
      end
    endcase
    return r;
  endfunction

  function automatic item_t make_item(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                     input logic [LEN_W-1:0] len,
                                     input logic [DATA_W-1:0] data);
    item_t it;
    it.mode       = mode;
    it.std_id     = id;
    it.frame_len  = len;
    it.frame_data = data;
    return it;
  endfunction

  task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic [PADDR_W-1:0] addr;
    addr = PADDR_W'(4 * idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program one filter and, for an index inside the filter list, read it back
  task automatic write_filter(input int idx, input logic [ID_W-1:0] id);
    logic [31:0] rdata;
    apb_access(1'b1, idx, {21'd0, id}, rdata);
    if (idx < NUM_FILTERS) begin
      queue_id[idx] = id;
      apb_access(1'b0, idx, '0, rdata);
      if (rdata !== {21'd0, id}) report_mismatch("filter readback", rdata, {21'd0, id});
    end
  endtask

  task automatic set_filters(input logic [ID_W-1:0] id0, input logic [ID_W-1:0] id1,
                             input logic [ID_W-1:0] id2);
    write_filter(REG_QUEUE0_ID, id0);
    write_filter(REG_QUEUE1_ID, id1);
    write_filter(REG_QUEUE2_ID, id2);
  endtask

  task automatic send_item(input item_t it);
    @(negedge clk);
    start   <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_queue_op(it));
  endtask

  task automatic sender_idle(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_gapped(input item_t it, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 13));
    send_item(it);
  endtask

  // Hold off until every expected result has arrived and the block is quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic item_t random_item(input int push_pct, input int pop_pct);
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) it.mode = MODE_PUSH;
    else if (pick < push_pct + pop_pct) it.mode = MODE_POP;
    else if (pick < 95) it.mode = MODE_COUNT;
    else it.mode = MODE_ALIAS_COUNT;
    if ($urandom_range(0, 9) == 0) it.std_id = ID_W'($urandom_range(0, 2047));
    else it.std_id = queue_id[$urandom_range(0, NUM_FILTERS - 1)];
    if ($urandom_range(0, 9) == 0) it.frame_len = LEN_W'($urandom_range(9, 15));
    else it.frame_len = LEN_W'($urandom_range(0, 8));
    it.frame_data = {$urandom, $urandom};
    return it;
  endfunction

  task automatic run_traffic(input int count, input int push_pct, input int pop_pct,
                             input bit gaps);
    repeat (count) send_gapped(random_item(push_pct, pop_pct), gaps);
  endtask

  task automatic test_reset_filters();
    logic [31:0] rdata;
    for (int i = 0; i < NUM_FILTERS; i++) begin
      apb_access(1'b0, i, '0, rdata);
      if (rdata !== {21'd0, queue_id[i]}) report_mismatch("reset filter", rdata, queue_id[i]);
    end
  endtask

  task automatic test_directed_edges();
    send_item(make_item(MODE_PUSH, 11'd1, 4'd0, 64'd0));
    send_item(make_item(MODE_PUSH, 11'd2, 4'd8, '1));
    send_item(make_item(MODE_PUSH, 11'd3, 4'd15, 64'h0123_4567_89ab_cdef));
    send_item(make_item(MODE_PUSH, 11'd1, 4'd9, 64'ha5a5_5a5a_f00f_0ff0));
    send_item(make_item(MODE_POP, 11'd1, 4'd0, 64'd0));
    send_item(make_item(MODE_POP, 11'd1, 4'd0, 64'd0));
    send_item(make_item(MODE_POP, 11'd1, 4'd0, 64'd0));
    send_item(make_item(MODE_COUNT, 11'd2, 4'd0, 64'd0));
    send_item(make_item(MODE_ALIAS_COUNT, 11'd3, 4'd0, 64'd0));
    send_item(make_item(MODE_POP, 11'd2, 4'd0, 64'd0));
    send_item(make_item(MODE_POP, 11'd3, 4'd0, 64'd0));
    send_item(make_item(MODE_PUSH, 11'd0, 4'd5, '1));
    send_item(make_item(MODE_POP, 11'd2047, 4'd0, 64'd0));
    drain();
    // overlapping filters: the highest queue takes the ID; spare index ignored
    set_filters(11'd0, 11'd2047, 11'd2047);
    write_filter(REG_UNUSED, 11'd5);
    send_item(make_item(MODE_PUSH, 11'd2047, 4'd8, 64'hffff_0000_ffff_0000));
    send_item(make_item(MODE_COUNT, 11'd2047, 4'd0, 64'd0));
    send_item(make_item(MODE_PUSH, 11'd0, 4'd1, 64'd1));
    send_item(make_item(MODE_COUNT, 11'd0, 4'd0, 64'd0));
    send_item(make_item(MODE_PUSH, 11'd5, 4'd2, 64'd2));
    send_item(make_item(MODE_PUSH, 11'd1, 4'd3, 64'd3));
    send_item(make_item(MODE_POP, 11'd2047, 4'd0, 64'd0));
    drain();
    set_filters(11'h2aa, 11'h2aa, 11'h2aa);
    send_item(make_item(MODE_PUSH, 11'h2aa, 4'd7, 64'h8000_0000_0000_0001));
    send_item(make_item(MODE_COUNT, 11'h2aa, 4'd0, 64'd0));
    send_item(make_item(MODE_POP, 11'h2aa, 4'd0, 64'd0));
    drain();
  endtask

  // Fill each ring past its seven usable slots, then empty it again
  task automatic test_fill_and_drop();
    int base;
    base = $urandom_range(0, 2045);
    set_filters(ID_W'(base), ID_W'(base + 1), ID_W'(base + 2));
    for (int q = 0; q < NUM_FILTERS; q++) begin
      repeat (9) begin
        send_gapped(make_item(MODE_PUSH, queue_id[q], LEN_W'($urandom_range(0, 8)),
                              {$urandom, $urandom}), 1'b1);
      end
      drain();
      send_item(make_item(MODE_COUNT, queue_id[q], 4'd0, 64'd0));
      repeat (8) send_gapped(make_item(MODE_POP, queue_id[q], 4'd0, 64'd0), 1'b1);
    end
    drain();
  endtask

  task automatic test_random_distinct_filters();
    set_filters(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                ID_W'($urandom_range(0, 2047)));
    run_traffic(300, 55, 30, 1'b1);
    drain();
  endtask

  task automatic test_random_extreme_filters();
    set_filters(11'd0, 11'd2047, ID_W'($urandom_range(1, 2046)));
    run_traffic(300, 35, 50, 1'b1);
    drain();
  endtask

  task automatic test_random_shared_filters();
    logic [ID_W-1:0] shared;
    shared = ID_W'($urandom_range(0, 2047));
    set_filters(ID_W'($urandom_range(0, 2047)), shared, shared);
    run_traffic(300, 45, 40, 1'b1);
    drain();
  endtask

  task automatic test_random_mixed_filters();
    set_filters(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                ID_W'($urandom_range(0, 2047)));
    run_traffic(300, 40, 35, 1'b1);
    drain();
  endtask

  task automatic test_back_to_back();
    set_filters(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                ID_W'($urandom_range(0, 2047)));
    run_traffic(220, 45, 40, 1'b0);
    drain();
  endtask

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      got = result_out;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", got.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.out_id !== want.out_id) report_mismatch("out_id", got.out_id, want.out_id);
        if (got.out_len !== want.out_len)
          report_mismatch("out_len", got.out_len, want.out_len);
        if (got.out_data !== want.out_data)
          report_mismatch("out_data", got.out_data, want.out_data);
        if (got.fill_count !== want.fill_count)
          report_mismatch("fill_count", got.fill_count, want.fill_count);
        if (got.received_count !== want.received_count)
          report_mismatch("received_count", got.received_count, want.received_count);
        if (got.dropped_count !== want.dropped_count)
          report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
      end
      result_index++;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("can_id_filtered_rx_queues_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    item_in        = '0;
    mismatch_count = 0;
    for (int q = 0; q < NUM_FILTERS; q++) begin
      queue_id[q]    = ID_W'(q + 1);
      wr_ptr[q]      = '0;
      rd_ptr[q]      = '0;
      frames_in[q]   = '0;
      frames_lost[q] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_filters();
    test_directed_edges();
    test_fill_and_drop();
    test_random_distinct_filters();
    test_random_extreme_filters();
    test_random_shared_filters();
    test_random_mixed_filters();
    test_back_to_back();

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("can_id_filtered_rx_queues_tb: PASS");
    end else begin
      $display("can_id_filtered_rx_queues_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> can_id_filtered_rx_queues.f
+incdir+src
src/canq_pkg.sv
src/canq_ram.sv
src/canq_front.sv
src/canq_back.sv
src/can_id_filtered_rx_queues.sv
tb/can_id_filtered_rx_queues_tb.sv
